/* design/toy_accumulator_cpu_execute_assert.svh */
// assertion macros for the toy accumulator cpu execute block
// expects clk and rst_n in the scope of the module that uses them
`ifndef TOY_ACCUMULATOR_CPU_EXECUTE_ASSERT_SVH
`define TOY_ACCUMULATOR_CPU_EXECUTE_ASSERT_SVH

`ifndef SYNTHESIS
`define TACE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TACE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TACE_ASSERT(lbl, prop, msg)
`define TACE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/tace_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and reset table for the toy accumulator cpu execute block
// no dependencies
package tace_pkg;

    localparam int INSTR_W   = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_REGS  = 8;
    localparam int REG_AW    = 3;
    localparam int MEM_DEPTH = 32;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [DATA_W-1:0] MEM_DEPTH_W      = DATA_W'(MEM_DEPTH);
    localparam logic [DATA_W-1:0] LOAD_ERROR_VALUE = '1;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_LOAD  = 2'd2,
        OP_STORE = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t           op;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] rs;
    } instr_t;

    localparam logic [REG_AW-1:0] REG_R1 = REG_AW'(1);
    localparam logic [REG_AW-1:0] REG_R2 = REG_AW'(2);
    localparam logic [REG_AW-1:0] REG_R3 = REG_AW'(3);

    // value of a register that has not been written since reset
    function automatic logic [DATA_W-1:0] rf_reset_value(input logic [REG_AW-1:0] idx);
        logic [DATA_W-1:0] v;
        case (idx)
            REG_R1:  v = DATA_W'(4);
            REG_R2:  v = DATA_W'(9);
            REG_R3:  v = DATA_W'(10);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* design/tace_in_if.sv */
`timescale 1ns / 1ps
// instruction channel: valid/ready handshake carrying one instruction word
// depends on tace_pkg
interface tace_in_if;
    import tace_pkg::*;

    logic               valid;
    logic               ready;
    logic [INSTR_W-1:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

/* design/tace_out_if.sv */
`timescale 1ns / 1ps
// result channel: valid/ready handshake carrying one execute result
// depends on tace_pkg
interface tace_out_if;
    import tace_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     reg_written;
    logic [REG_AW-1:0]        dest_index;
    logic signed [DATA_W-1:0] written_value;
    logic                     mem_written;
    logic signed [DATA_W-1:0] mem_address;
    logic                     bounds_error;

    modport source (output valid, output reg_written, output dest_index,
                    output written_value, output mem_written, output mem_address,
                    output bounds_error, input ready);
    modport sink   (input valid, input reg_written, input dest_index,
                    input written_value, input mem_written, input mem_address,
                    input bounds_error, output ready);
endinterface

/* design/tace_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data (read-first)
// no dependencies
module tace_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/toy_accumulator_cpu_execute.sv */
`timescale 1ns / 1ps
// toy accumulator cpu execute block: add, sub, load, store on eight 32-bit registers
// and a small data memory
// depends on tace_pkg, tace_in_if, tace_out_if, tace_ram and the assertion header
//
// usage:
//   cmd carries one 8-bit instruction per transaction, rsp returns one result
//   transaction per instruction, in order.
//   a taken instruction is registered into the operand stage, then into the output
//   stage, where rsp.valid rises. throughput: one instruction per cycle while
//   rsp.ready is high; the register file is read from two ram copies when the
//   instruction is taken and written when its result leaves, with forwarding from
//   the output stage and from the last write covering the gap.
//   loads read data memory as the operand stage advances, after the register read,
//   stores write it at the same point, so memory accesses stay in program order.
//   reset: registers come up as 0,4,9,10 and zeros, data memory as all zeros, both
//   through per-entry valid bits, so the block takes instructions right away.
//   stall: when rsp.ready is low the result holds in the output stage, one more
//   instruction can be taken into the operand stage, then cmd.ready drops.
`include "toy_accumulator_cpu_execute_assert.svh"
module toy_accumulator_cpu_execute (
    input  logic clk,
    input  logic rst_n,
    tace_in_if.sink    cmd,
    tace_out_if.source rsp
);
    import tace_pkg::*;

    instr_t in_instr;
    logic   accept;
    logic   s1_adv;
    logic   s2_take;

    // operand stage
    logic              s1_valid_reg;
    opcode_t           s1_op_reg;
    logic [REG_AW-1:0] s1_rd_reg;
    logic [REG_AW-1:0] s1_rs_reg;
    logic              s1_a_ok_reg;
    logic              s1_b_ok_reg;

    // output stage
    logic              s2_valid_reg;
    opcode_t           s2_op_reg;
    logic [REG_AW-1:0] s2_rd_reg;
    logic [DATA_W-1:0] s2_val_reg;
    logic [DATA_W-1:0] s2_addr_reg;
    logic              s2_in_range_reg;
    logic              s2_dok_reg;

    // last register write, covers a read issued at the same edge
    logic              lw_valid_reg;
    logic [REG_AW-1:0] lw_idx_reg;
    logic [DATA_W-1:0] lw_data_reg;

    logic [NUM_REGS-1:0]  rf_valid_reg;
    logic [MEM_DEPTH-1:0] dm_valid_reg;

    logic [DATA_W-1:0] rf_a_q;
    logic [DATA_W-1:0] rf_b_q;
    logic [DATA_W-1:0] dm_q;
    logic              rf_we;
    logic              dm_we;
    logic              dm_re;
    logic [MEM_AW-1:0] dm_addr;

    logic [DATA_W-1:0] s1_a;
    logic [DATA_W-1:0] s1_b;
    logic [DATA_W-1:0] s1_alu;
    logic [DATA_W-1:0] s1_addr;
    logic              s1_in_range;
    logic              s2_regw;
    logic [DATA_W-1:0] s2_result;

    assign in_instr = instr_t'(cmd.instruction_word);
    assign s2_take  = s2_valid_reg && rsp.ready;
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign accept   = cmd.valid && cmd.ready;

    tace_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_rd_reg),
        .wdata (s2_result),
        .re    (accept),
        .raddr (in_instr.rd),
        .rdata (rf_a_q)
    );

    tace_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_rd_reg),
        .wdata (s2_result),
        .re    (accept),
        .raddr (in_instr.rs),
        .rdata (rf_b_q)
    );

    tace_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_addr),
        .wdata (s1_a),
        .re    (dm_re),
        .raddr (dm_addr),
        .rdata (dm_q)
    );

    // output stage result, also the register write data
    always_comb
    begin
        case (s2_op_reg)
            OP_LOAD:
            begin
                if (!s2_in_range_reg)
                begin
                    s2_result = LOAD_ERROR_VALUE;
                end
                else if (s2_dok_reg)
                begin
                    s2_result = dm_q;
                end
                else
                begin
                    s2_result = '0;
                end
            end
            default: s2_result = s2_val_reg;
        endcase
    end

    assign s2_regw = (s2_op_reg != OP_STORE);
    assign rf_we   = s2_take && s2_regw;

    // operand forwarding: output stage first, then last write, then ram, then reset value
    always_comb
    begin
        if (s2_valid_reg && s2_regw && (s2_rd_reg == s1_rd_reg))
        begin
            s1_a = s2_result;
        end
        else if (lw_valid_reg && (lw_idx_reg == s1_rd_reg))
        begin
            s1_a = lw_data_reg;
        end
        else if (s1_a_ok_reg)
        begin
            s1_a = rf_a_q;
        end
        else
        begin
            s1_a = rf_reset_value(s1_rd_reg);
        end

        if (s2_valid_reg && s2_regw && (s2_rd_reg == s1_rs_reg))
        begin
            s1_b = s2_result;
        end
        else if (lw_valid_reg && (lw_idx_reg == s1_rs_reg))
        begin
            s1_b = lw_data_reg;
        end
        else if (s1_b_ok_reg)
        begin
            s1_b = rf_b_q;
        end
        else
        begin
            s1_b = rf_reset_value(s1_rs_reg);
        end
    end

    always_comb
    begin
        case (s1_op_reg)
            OP_ADD:  s1_alu = s1_a + s1_b;
            OP_SUB:  s1_alu = s1_a - s1_b;
            default: s1_alu = s1_a;
        endcase
    end

    // unsigned compare also rejects negative addresses
    assign s1_in_range = (s1_b < MEM_DEPTH_W);
    assign s1_addr = ((s1_op_reg == OP_LOAD) || (s1_op_reg == OP_STORE)) ? s1_b : '0;
    assign dm_addr = s1_b[MEM_AW-1:0];
    assign dm_we   = s1_adv && (s1_op_reg == OP_STORE) && s1_in_range;
    assign dm_re   = s1_adv && (s1_op_reg == OP_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            rf_valid_reg <= '0;
            dm_valid_reg <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_take)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (rf_we)
            begin
                lw_valid_reg            <= 1'b1;
                rf_valid_reg[s2_rd_reg] <= 1'b1;
            end
            if (dm_we)
            begin
                dm_valid_reg[dm_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= in_instr.op;
            s1_rd_reg   <= in_instr.rd;
            s1_rs_reg   <= in_instr.rs;
            s1_a_ok_reg <= rf_valid_reg[in_instr.rd];
            s1_b_ok_reg <= rf_valid_reg[in_instr.rs];
        end
        if (s1_adv)
        begin
            s2_op_reg       <= s1_op_reg;
            s2_rd_reg       <= s1_rd_reg;
            s2_val_reg      <= s1_alu;
            s2_addr_reg     <= s1_addr;
            s2_in_range_reg <= s1_in_range;
            s2_dok_reg      <= dm_valid_reg[dm_addr];
        end
        if (rf_we)
        begin
            lw_idx_reg  <= s2_rd_reg;
            lw_data_reg <= s2_result;
        end
    end

    assign rsp.valid         = s2_valid_reg;
    assign rsp.reg_written   = s2_regw;
    assign rsp.dest_index    = s2_rd_reg;
    assign rsp.written_value = s2_result;
    assign rsp.mem_written   = (s2_op_reg == OP_STORE) && s2_in_range_reg;
    assign rsp.mem_address   = s2_addr_reg;
    assign rsp.bounds_error  = ((s2_op_reg == OP_LOAD) || (s2_op_reg == OP_STORE))
                               && !s2_in_range_reg;

    `TACE_ASSERT(a_no_dm_read_on_stall, (s2_valid_reg && !rsp.ready) |-> !dm_re, "load data overwritten while result stalled")
    `TACE_ASSERT(a_store_in_range, dm_we |-> (s1_b < MEM_DEPTH_W), "store wrote outside data memory")
    `TACE_ASSERT(a_ready_when_drained, rsp.ready |-> cmd.ready, "instruction channel blocked while results drain")
    `TACE_ASSERT_NEXT(a_take_fills_stage, accept, s1_valid_reg, "accepted instruction lost from operand stage")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// testbench for toy_accumulator_cpu_execute: directed and random instruction streams,
// checked against a shadow copy of the register file and data memory
// depends on tace_pkg, tace_in_if, tace_out_if and the block itself
module tb_top;
    import tace_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1330;

    typedef struct packed {
        logic              reg_written;
        logic [REG_AW-1:0] dest_index;
        logic [DATA_W-1:0] written_value;
        logic              mem_written;
        logic [DATA_W-1:0] mem_address;
        logic              bounds_error;
    } exec_result_t;

    logic clk;
    logic rst_n;

    tace_in_if  cmd_if();
    tace_out_if rsp_if();

    toy_accumulator_cpu_execute DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    logic [DATA_W-1:0] regs_shadow [NUM_REGS];
    logic [DATA_W-1:0] dmem_shadow [MEM_DEPTH];
    exec_result_t      results_due [$];
    int                fail_count;
    bit                sender_steady;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic instr_t mk_instr(opcode_t op, int rd, int rs);
        instr_t w;
        w.op = op;
        w.rd = REG_AW'(rd);
        w.rs = REG_AW'(rs);
        return w;
    endfunction

    // executes one instruction on the shadow state and returns its result
    function automatic exec_result_t predict_execute(instr_t w);
        exec_result_t      r;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              hit;
        a   = regs_shadow[w.rd];
        b   = regs_shadow[w.rs];
        // unsigned compare also rejects negative addresses
        hit = (b < MEM_DEPTH_W);
        r   = '0;
        r.dest_index = w.rd;
        case (w.op)
            OP_ADD:
            begin
                r.written_value = a + b;
                r.reg_written   = 1'b1;
            end
            OP_SUB:
            begin
                r.written_value = a - b;
                r.reg_written   = 1'b1;
            end
            OP_LOAD:
            begin
                r.mem_address   = b;
                r.reg_written   = 1'b1;
                r.bounds_error  = !hit;
                r.written_value = hit ? dmem_shadow[b[MEM_AW-1:0]] : LOAD_ERROR_VALUE;
            end
            OP_STORE:
            begin
                r.mem_address   = b;
                r.written_value = a;
                r.mem_written   = hit;
                r.bounds_error  = !hit;
                if (hit)
                    dmem_shadow[b[MEM_AW-1:0]] = a;
            end
        endcase
        if (r.reg_written)
            regs_shadow[w.rd] = r.written_value;
        return r;
    endfunction

    // favors loads and stores through registers that hold a valid address,
    // and rebuilds small values when few are left
    function automatic instr_t next_random_instr();
        instr_t            w;
        int unsigned       roll;
        logic [REG_AW-1:0] addr_regs [$];
        w    = instr_t'(INSTR_W'($urandom_range(0, 255)));
        roll = $urandom_range(0, 99);
        for (int i = 0; i < NUM_REGS; i++)
            if (regs_shadow[i] < MEM_DEPTH_W)
                addr_regs = {addr_regs, REG_AW'(i)};
        if (roll < 50 && addr_regs.size() > 0)
        begin
            w.op = (roll < 25) ? OP_LOAD : OP_STORE;
            w.rs = addr_regs[$urandom_range(0, addr_regs.size() - 1)];
        end
        else if (roll < 62 && addr_regs.size() < 4)
        begin
            // clear a register
            w.op = OP_SUB;
            w.rs = w.rd;
        end
        else if (roll < 72 && addr_regs.size() > 0)
        begin
            w.op = OP_ADD;
            w.rs = addr_regs[$urandom_range(0, addr_regs.size() - 1)];
        end
        return w;
    endfunction

    task automatic send_instr(input instr_t w);
        @(negedge clk);
        cmd_if.valid            <= 1'b1;
        cmd_if.instruction_word <= w;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        results_due = {results_due, predict_execute(w)};
        repeat (sender_steady ? 0 : idle_len())
        begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_list(input instr_t prog [$]);
        foreach (prog[i])
            send_instr(prog[i]);
    endtask

    // reads the reset values and builds addresses 31 and 32
    task automatic test_reset_state();
        instr_t prog [$];
        prog = '{mk_instr(OP_ADD, 4, 2), mk_instr(OP_ADD, 4, 2),
                 mk_instr(OP_ADD, 4, 1), mk_instr(OP_ADD, 4, 3),
                 mk_instr(OP_ADD, 5, 3), mk_instr(OP_SUB, 5, 2),
                 mk_instr(OP_ADD, 6, 4), mk_instr(OP_SUB, 6, 5),
                 mk_instr(OP_LOAD, 0, 0)};
        send_list(prog);
    endtask

    // last valid address and first invalid one
    task automatic test_mem_bounds();
        instr_t prog [$];
        prog = '{mk_instr(OP_STORE, 3, 6), mk_instr(OP_STORE, 2, 4),
                 mk_instr(OP_LOAD, 7, 6), mk_instr(OP_LOAD, 7, 4),
                 mk_instr(OP_STORE, 7, 0), mk_instr(OP_LOAD, 5, 0),
                 mk_instr(OP_LOAD, 1, 1)};
        send_list(prog);
    endtask

    // carry out of add, borrow of sub, then negative and all-ones addresses
    task automatic test_wrap();
        instr_t prog [$];
        prog = '{mk_instr(OP_ADD, 5, 3), mk_instr(OP_SUB, 0, 3),
                 mk_instr(OP_LOAD, 2, 0), mk_instr(OP_STORE, 1, 0),
                 mk_instr(OP_SUB, 7, 7), mk_instr(OP_STORE, 7, 2)};
        send_list(prog);
    endtask

    task automatic test_random_programs(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
                sender_steady = ($urandom_range(0, 3) == 0);
            // hold off now and then until every result is back
            if (n % 450 == 449)
                wait_drained();
            send_instr(next_random_instr());
        end
    endtask

    initial
    begin : rsp_ready_drive
        int stall;
        int cycles;
        bit calm;
        rsp_if.ready = 1'b0;
        stall  = 0;
        cycles = 0;
        calm   = 1'b0;
        forever
        begin
            @(negedge clk);
            cycles++;
            if (cycles % 250 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (!calm)
                    stall = idle_len();
            end
        end
    end

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_rsp
        exec_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("result transaction with no instruction outstanding");
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("reg_written", DATA_W'(want.reg_written),
                            DATA_W'(rsp_if.reg_written));
                check_field("dest_index", DATA_W'(want.dest_index),
                            DATA_W'(rsp_if.dest_index));
                check_field("written_value", want.written_value, rsp_if.written_value);
                check_field("mem_written", DATA_W'(want.mem_written),
                            DATA_W'(rsp_if.mem_written));
                check_field("mem_address", want.mem_address, rsp_if.mem_address);
                check_field("bounds_error", DATA_W'(want.bounds_error),
                            DATA_W'(rsp_if.bounds_error));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n                   = 1'b0;
        cmd_if.valid            = 1'b0;
        cmd_if.instruction_word = '0;
        fail_count              = 0;
        sender_steady           = 1'b0;
        regs_shadow             = '{32'd0, 32'd4, 32'd9, 32'd10, 32'd0, 32'd0, 32'd0, 32'd0};
        foreach (dmem_shadow[i])
            dmem_shadow[i] = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_mem_bounds();
        test_wrap();
        test_random_programs(RANDOM_ITEMS);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/tace_pkg.sv
design/tace_in_if.sv
design/tace_out_if.sv
design/tace_ram.sv
design/toy_accumulator_cpu_execute.sv
tb/tb_top.sv
